// ===== hw/rtl/clp_pkg.sv =====
// Package with the character codes, mode codes and widths of the command line parser.
package clp_pkg;

	// Width of each field accumulator.
	localparam int unsigned ACC_WIDTH = 32;
	// Width of each result field.
	localparam int unsigned OUT_WIDTH = 32;
	// Width of the field index.
	localparam int unsigned IDX_WIDTH = 2;
	// Number of fields.
	localparam int unsigned NUM_FIELDS = 3;

	typedef logic [ACC_WIDTH-1:0] acc_t;
	typedef logic [OUT_WIDTH-1:0] out_t;
	typedef logic [IDX_WIDTH-1:0] idx_t;

	// Characters that the parser reacts to.
	localparam logic [7:0] CH_M       = 8'h4D;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_B       = 8'h42;
	localparam logic [7:0] CH_V       = 8'h56;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_C       = 8'h43;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] DIGIT_LO   = 8'd48;
	localparam logic [7:0] DIGIT_HI   = 8'd58;

	// Mode codes stored in field 0.
	localparam acc_t MODE_M = acc_t'(1);
	localparam acc_t MODE_A = acc_t'(2);
	localparam acc_t MODE_H = acc_t'(3);
	localparam acc_t MODE_D = acc_t'(4);
	localparam acc_t MODE_B = acc_t'(5);
	localparam acc_t MODE_V = acc_t'(6);
	localparam acc_t MODE_S = acc_t'(7);
	localparam acc_t MODE_C = acc_t'(9);

	// Highest field index; the index saturates here.
	localparam idx_t IDX_LAST = idx_t'(NUM_FIELDS - 1);

endpackage

// ===== hw/rtl/command_line_parser_top.sv =====
// Top level of the command line parser: byte input stage, field accumulators, result register.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one text byte per beat.
//   Mode letters M, A, H, D, B, V, S, C set field 0 to a mode code; C and comma
//   step the field index, which stops at field 2. Bytes '0' to ':' append a
//   decimal digit to the selected field, except while field 0 holds the H code.
//   A newline sends one beat on the master channel (m_tvalid, m_tready,
//   m_tdata) with the three fields and then clears fields and index.
// Pipeline and throughput:
//   A byte is taken into the input register and from there updates the
//   fields; a newline loads the result register at that point, and that
//   register drives m_tvalid. One byte is taken every cycle unless a newline
//   stalls; the shift-and-add by ten plus one add of a digit is combinational.
// Stall:
//   While a result waits in the result register, other bytes keep flowing.
//   Only a second newline waits in the input register until the result is
//   taken, and then s_tready falls.
// Reset:
//   arst_n clears fields, index and both valid flags at once; the block is
//   ready as soon as reset is released.
module command_line_parser_top
	import clp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // [31:0] mode_value, [63:32] first_value, [95:64] second_value
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	acc_t field_q [NUM_FIELDS];
	idx_t index_q;

	// Result register.
	logic         out_valid_q;
	out_t         out_mode_q;
	out_t         out_first_q;
	out_t         out_second_q;

	// Control.
	logic is_newline;
	logic is_digit;
	logic out_free;
	logic advance;
	logic [3:0] digit_val;
	acc_t sel_field;
	acc_t next_field;
	acc_t field_d [NUM_FIELDS];
	idx_t index_d;

	// The input stage moves on unless it holds a newline and the result register is busy.
	assign is_newline = (byte_s1 == CH_NEWLINE);
	assign out_free   = !out_valid_q || m_tready;
	assign advance    = valid_s1 && (!is_newline || out_free);
	assign s_tready   = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Digit update: field times ten plus the digit, wrapped to the accumulator width.
	assign is_digit   = (byte_s1 >= DIGIT_LO) && (byte_s1 <= DIGIT_HI) && (field_q[0] != MODE_H);
	assign digit_val  = 4'(byte_s1 - DIGIT_LO);
	assign sel_field  = field_q[index_q];
	assign next_field = (sel_field << 3) + (sel_field << 1) + acc_t'(digit_val);

	// Next state of fields and index.
	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			field_d[i] = field_q[i];
		end
		index_d = index_q;
		unique case (byte_s1)
			CH_M: field_d[0] = MODE_M;
			CH_A: field_d[0] = MODE_A;
			CH_H: field_d[0] = MODE_H;
			CH_D: field_d[0] = MODE_D;
			CH_B: field_d[0] = MODE_B;
			CH_V: field_d[0] = MODE_V;
			CH_S: field_d[0] = MODE_S;
			CH_C: begin
				field_d[0] = MODE_C;
				if (index_q != IDX_LAST) index_d = index_q + idx_t'(1);
			end
			CH_COMMA: begin
				if (index_q != IDX_LAST) index_d = index_q + idx_t'(1);
			end
			CH_NEWLINE: begin
				for (int i = 0; i < NUM_FIELDS; i++) begin
					field_d[i] = '0;
				end
				index_d = '0;
			end
			default: begin
				if (is_digit) field_d[index_q] = next_field;
			end
		endcase
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				field_q[i] <= '0;
			end
			index_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				field_q[i] <= field_d[i];
			end
			index_q <= index_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_newline) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded when a newline leaves the input stage.
	always_ff @(posedge clk) begin
		if (advance && is_newline) begin
			out_mode_q   <= OUT_WIDTH'(field_q[0]);
			out_first_q  <= OUT_WIDTH'(field_q[1]);
			out_second_q <= OUT_WIDTH'(field_q[2]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_second_q, out_first_q, out_mode_q};

	// The field index never passes the last field.
	assert property (@(posedge clk) disable iff (!arst_n) index_q <= IDX_LAST)
		else $error("field index beyond last field");

	// A newline clears the whole parser state.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_newline |=> index_q == '0 && field_q[0] == '0 &&
			field_q[1] == '0 && field_q[2] == '0)
		else $error("state not cleared after newline");

	// Digits are ignored while field 0 holds the H code.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 >= DIGIT_LO && byte_s1 <= DIGIT_HI && field_q[0] == MODE_H
		|=> $stable(field_q[1]) && $stable(field_q[2]) && field_q[0] == MODE_H)
		else $error("digit changed a field in H mode");

	// The input side stalls only behind a newline that waits for the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && is_newline && out_valid_q && !m_tready)
		else $error("input stalled without a waiting newline");

endmodule

// ===== tb/command_line_parser_top_test.sv =====
// Self-checking testbench for the command line parser: byte stimulus, line predictor, result check.
module command_line_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import clp_pkg::*;

	// One parsed command line as it leaves on the master channel, highest field first.
	typedef struct packed {
		out_t second_value;
		out_t first_value;
		out_t mode_value;
	} line_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // [31:0] mode_value, [63:32] first_value, [95:64] second_value

	// Predictor state: the three field accumulators and the field selector.
	acc_t field_acc [NUM_FIELDS];
	idx_t field_sel;

	// Lines that the predictor has closed and that the block still owes.
	line_result_t expected_lines [$];

	int unsigned mismatches;
	bit          tx_idle_en;
	bit          rx_idle_en;
	int unsigned rx_hold_off;
	int unsigned live_items;

	// Mode letters in the order of their codes.
	logic [7:0] mode_chars [8] = '{CH_M, CH_A, CH_H, CH_D, CH_B, CH_V, CH_S, CH_C};

	command_line_parser_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Update the predictor with one accepted byte and queue a line on newline.
	task automatic predict_byte(input logic [7:0] b);
		line_result_t line;
		case (b)
			CH_M: field_acc[0] = MODE_M;
			CH_A: field_acc[0] = MODE_A;
			CH_H: field_acc[0] = MODE_H;
			CH_D: field_acc[0] = MODE_D;
			CH_B: field_acc[0] = MODE_B;
			CH_V: field_acc[0] = MODE_V;
			CH_S: field_acc[0] = MODE_S;
			CH_C: begin
				field_acc[0] = MODE_C;
				if (field_sel < IDX_LAST) field_sel++;
			end
			CH_COMMA: begin
				if (field_sel < IDX_LAST) field_sel++;
			end
			CH_NEWLINE: begin
				line.mode_value   = out_t'(field_acc[0]);
				line.first_value  = out_t'(field_acc[1]);
				line.second_value = out_t'(field_acc[2]);
				expected_lines.push_back(line);
				foreach (field_acc[i]) field_acc[i] = '0;
				field_sel = '0;
			end
			default: begin
				// Digits and the colon append to the selected field, except in H mode.
				if (b >= DIGIT_LO && b <= DIGIT_HI && field_acc[0] != MODE_H)
					field_acc[field_sel] = field_acc[field_sel] * acc_t'(10) +
						acc_t'(b - DIGIT_LO);
			end
		endcase
	endtask

	// Offer one byte after a random gap and predict it once the beat is taken.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = tx_idle_en ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
	endtask

	// Receiver: random wait before each result, with an optional long hold-off.
	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 7) : 0;
			if (rx_hold_off > 0) begin
				gap = rx_hold_off;
				rx_hold_off = 0;
			end
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Compare each result beat with the oldest predicted line.
	always @(posedge clk) begin
		line_result_t got;
		line_result_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: mode %0d first %0d second %0d",
						got.mode_value, got.first_value, got.second_value);
			end else begin
				want = expected_lines.pop_front();
				if (got.mode_value !== want.mode_value ||
						got.first_value !== want.first_value ||
						got.second_value !== want.second_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected mode %0d first %0d second %0d, got mode %0d first %0d second %0d",
							want.mode_value, want.first_value, want.second_value,
							got.mode_value, got.first_value, got.second_value);
				end
			end
		end
	end

	// Each mode letter but H and C on a line of its own.
	task automatic test_mode_letters();
		foreach (mode_chars[i]) begin
			if (mode_chars[i] != CH_H && mode_chars[i] != CH_C) begin
				send_byte(mode_chars[i]);
				send_byte(CH_NEWLINE);
			end
		end
	endtask

	// C and two commas try to push the index past the last field; it must stay there.
	task automatic test_index_saturation();
		send_byte(CH_C);
		send_byte(CH_COMMA);
		send_byte(CH_COMMA);
		send_byte(DIGIT_HI);
		send_byte(DIGIT_LO + 8'd7);
		send_byte(CH_NEWLINE);
	endtask

	// In H mode all digit bytes are dropped.
	task automatic test_h_mode_digits();
		send_byte(CH_H);
		send_byte(DIGIT_LO + 8'd5);
		send_byte(CH_COMMA);
		send_byte(DIGIT_HI);
		send_byte(CH_NEWLINE);
	endtask

	// Byte extremes and the neighbors of the digit range, then digits into field 0.
	task automatic test_byte_extremes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(DIGIT_LO - 8'd1);
		send_byte(DIGIT_HI + 8'd1);
		send_byte(DIGIT_LO);
		send_byte(DIGIT_LO + 8'd9);
		send_byte(CH_NEWLINE);
	endtask

	// Hold the receiver off while newlines keep coming, so the input has to stall.
	task automatic test_backpressure();
		rx_hold_off = 300;
		repeat (6) begin
			send_byte(CH_M);
			send_byte(DIGIT_LO + 8'd1);
			send_byte(CH_NEWLINE);
		end
	endtask

	// Send a counted byte, now and then preceded by a noise byte.
	task automatic send_live(input logic [7:0] b);
		if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)));
		send_byte(b);
		live_items++;
	endtask

	// Random digit run: mostly short, sometimes long enough to wrap 32 bits.
	task automatic send_digits();
		int unsigned n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
		repeat (n) send_live(DIGIT_LO + 8'($urandom_range(0, 10)));
	endtask

	// Mostly well-formed lines with random content, plus broken lines and noise.
	task automatic test_random_lines();
		int unsigned kind;
		int unsigned n;
		live_items = 0;
		while (live_items < 1000) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_live(mode_chars[$urandom_range(0, 7)]);
				send_digits();
				send_live(CH_COMMA);
				send_digits();
				send_live(CH_NEWLINE);
			end else if (kind < 9) begin
				// Broken line: letters, commas and digits in any order.
				n = $urandom_range(1, 12);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: send_live(mode_chars[$urandom_range(0, 7)]);
						1: send_live(CH_COMMA);
						default: send_live(DIGIT_LO + 8'($urandom_range(0, 10)));
					endcase
				end
				send_live(CH_NEWLINE);
			end else begin
				// Pure noise, sometimes closed by a newline.
				n = $urandom_range(1, 6);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 1) send_live(CH_NEWLINE);
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Main sequence: reset, directed tests, random lines, drain and verdict.
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		mismatches  = 0;
		tx_idle_en  = 1'b1;
		rx_idle_en  = 1'b1;
		rx_hold_off = 0;
		foreach (field_acc[i]) field_acc[i] = '0;
		field_sel = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_mode_letters();
		test_index_saturation();
		test_h_mode_digits();
		test_byte_extremes();
		test_backpressure();
		test_random_lines();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("** command_line_parser_top: PASSED **");
		end else begin
			$display("** command_line_parser_top: FAILED **");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5ms;
		$display("** command_line_parser_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/clp_pkg.sv
hw/rtl/command_line_parser_top.sv
tb/command_line_parser_top_test.sv
